/* sv/esd_pkg.sv */
// ----------------------------------------------------------------------------
// Event subscription dispatcher package
// Shared constants, command and status codes, and the queue item type.
// ----------------------------------------------------------------------------
package esd_pkg;

	localparam int TABLE_SLOTS_DEF = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int Q_AW        = 1;

	localparam logic [4:0] SLOTS_RST = 5'd16;

	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_SUB     = 2'd1;
	localparam logic [1:0] CMD_UNSUB   = 2'd2;
	localparam logic [1:0] CMD_PUBLISH = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NULL     = 3'd1;
	localparam logic [2:0] ST_EXISTS   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// item class decided by the front end
	localparam logic [2:0] K_CLEAR = 3'd0;
	localparam logic [2:0] K_NULL  = 3'd1;
	localparam logic [2:0] K_SUB   = 3'd2;
	localparam logic [2:0] K_UNSUB = 3'd3;
	localparam logic [2:0] K_PUB   = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] event_number;
		logic [15:0] handler_id;
		logic [31:0] context_word;
		logic [31:0] payload_word;
	} cmd_t;

endpackage

/* sv/esd_front.sv */
// ----------------------------------------------------------------------------
// Dispatcher front end
// Accepts items, classifies the command and queues it for the table engine.
// ----------------------------------------------------------------------------
module esd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [15:0]         event_number,
	input  logic [15:0]         handler_id,
	input  logic [31:0]         context_word,
	input  logic [31:0]         payload_word,
	output logic                q_valid,
	input  logic                q_ready,
	output esd_pkg::cmd_t       q_cmd
);

	esd_pkg::cmd_t                fifo_q [esd_pkg::QUEUE_DEPTH];
	logic [esd_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [esd_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [esd_pkg::Q_AW:0]       count_q;
	logic                         push;
	logic                         pop;
	esd_pkg::cmd_t                cls;

	always_comb begin
		cls.event_number = event_number;
		cls.handler_id   = handler_id;
		cls.context_word = context_word;
		cls.payload_word = payload_word;
		unique case (command)
			esd_pkg::CMD_CLEAR:   cls.kind = esd_pkg::K_CLEAR;
			esd_pkg::CMD_SUB:     cls.kind = (handler_id == 16'd0) ? esd_pkg::K_NULL
			                                                        : esd_pkg::K_SUB;
			esd_pkg::CMD_UNSUB:   cls.kind = (handler_id == 16'd0) ? esd_pkg::K_NULL
			                                                        : esd_pkg::K_UNSUB;
			esd_pkg::CMD_PUBLISH: cls.kind = esd_pkg::K_PUB;
			default:              cls.kind = esd_pkg::K_PUB;
		endcase
	end

	assign in_ready = (count_q < (esd_pkg::Q_AW + 1)'(esd_pkg::QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_cmd    = fifo_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + esd_pkg::Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + esd_pkg::Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (esd_pkg::Q_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (esd_pkg::Q_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (esd_pkg::Q_AW + 1)'(esd_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

/* sv/esd_back.sv */
// ----------------------------------------------------------------------------
// Dispatcher table engine
// Scans the subscription table one slot a cycle unless a dispatch stalls, and produces the results.
// ----------------------------------------------------------------------------
module esd_back #(
	parameter int TABLE_SLOTS = esd_pkg::TABLE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          slots_in_use,
	input  logic                q_valid,
	output logic                q_ready,
	input  esd_pkg::cmd_t       q_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic                is_dispatch,
	output logic [15:0]         dispatch_handler,
	output logic [31:0]         dispatch_context,
	output logic [15:0]         dispatch_event,
	output logic [31:0]         dispatch_payload,
	output logic [4:0]          active_subscriptions,
	output logic                last
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [63:0]            tbl_mem [TABLE_SLOTS];
	logic [63:0]            rd_s1;
	logic                   v_s1;
	logic [IW-1:0]          idx_s1;
	logic [1:0]             state_q;
	esd_pkg::cmd_t          cmd_q;
	logic [CW-1:0]          ia_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_idx_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [CW-1:0]          active_q;
	logic [2:0]             done_status_q;
	logic                   out_valid_q;

	logic [CW-1:0]          n;
	logic                   emit_ok;
	logic                   is_pub;
	logic                   hit_s1;
	logic                   more;
	logic                   scan_go;
	logic                   scan_end;
	logic                   rd_en;
	logic                   tbl_we;
	logic                   emit_disp;
	logic                   emit_done;

	always_comb begin
		if (int'(slots_in_use) > TABLE_SLOTS) begin
			n = CW'(TABLE_SLOTS);
		end else begin
			n = CW'(slots_in_use);
		end
	end

	assign emit_ok   = !out_valid_q || out_ready;
	assign is_pub    = (cmd_q.kind == esd_pkg::K_PUB);
	assign hit_s1    = v_s1 && valid_q[idx_s1] && (rd_s1[63:48] == cmd_q.event_number)
	                   && (is_pub || (rd_s1[47:32] == cmd_q.handler_id));
	assign more      = (ia_q < n);
	assign scan_go   = !(hit_s1 && is_pub && !emit_ok);
	assign scan_end  = !v_s1 && !more;
	assign rd_en     = (state_q == S_SCAN) && scan_go && more;
	assign tbl_we    = (state_q == S_SCAN) && !hit_s1 && scan_end
	                   && (cmd_q.kind == esd_pkg::K_SUB) && free_found_q;
	assign emit_disp = (state_q == S_SCAN) && hit_s1 && is_pub && emit_ok;
	assign emit_done = (state_q == S_DONE) && emit_ok;
	assign q_ready   = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ia_q          <= '0;
			v_s1          <= 1'b0;
			idx_s1        <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			valid_q       <= '0;
			active_q      <= '0;
			done_status_q <= esd_pkg::ST_OK;
			out_valid_q   <= 1'b0;
		end else begin
			if (emit_disp || emit_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q.kind)
						esd_pkg::K_CLEAR: begin
							valid_q       <= '0;
							active_q      <= '0;
							done_status_q <= esd_pkg::ST_OK;
							state_q       <= S_DONE;
						end
						esd_pkg::K_NULL: begin
							done_status_q <= esd_pkg::ST_NULL;
							state_q       <= S_DONE;
						end
						default: begin
							ia_q         <= '0;
							v_s1         <= 1'b0;
							free_found_q <= 1'b0;
							state_q      <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					if (scan_go) begin
						v_s1   <= more;
						idx_s1 <= ia_q[IW-1:0];
						if (more) begin
							ia_q <= ia_q + CW'(1);
						end
					end
					if (v_s1 && !valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_s1;
					end
					if (hit_s1) begin
						case (cmd_q.kind)
							esd_pkg::K_SUB: begin
								done_status_q <= esd_pkg::ST_EXISTS;
								state_q       <= S_DONE;
							end
							esd_pkg::K_UNSUB: begin
								valid_q[idx_s1] <= 1'b0;
								active_q        <= active_q - CW'(1);
								done_status_q   <= esd_pkg::ST_OK;
								state_q         <= S_DONE;
							end
							default: begin
							end
						endcase
					end else if (scan_end) begin
						state_q <= S_DONE;
						case (cmd_q.kind)
							esd_pkg::K_SUB: begin
								if (free_found_q) begin
									valid_q[free_idx_q] <= 1'b1;
									active_q            <= active_q + CW'(1);
									done_status_q       <= esd_pkg::ST_OK;
								end else begin
									done_status_q <= esd_pkg::ST_FULL;
								end
							end
							esd_pkg::K_UNSUB: done_status_q <= esd_pkg::ST_NOTFOUND;
							default:          done_status_q <= esd_pkg::ST_OK;
						endcase
					end
				end
				S_DONE: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			cmd_q <= q_cmd;
		end
		if (rd_en) begin
			rd_s1 <= tbl_mem[ia_q[IW-1:0]];
		end
		if (tbl_we) begin
			tbl_mem[free_idx_q] <= {cmd_q.event_number, cmd_q.handler_id, cmd_q.context_word};
		end
	end

	always_ff @(posedge clk) begin
		if (emit_disp) begin
			status               <= esd_pkg::ST_OK;
			is_dispatch          <= 1'b1;
			dispatch_handler     <= rd_s1[47:32];
			dispatch_context     <= rd_s1[31:0];
			dispatch_event       <= cmd_q.event_number;
			dispatch_payload     <= cmd_q.payload_word;
			active_subscriptions <= 5'(32'(active_q));
			last                 <= 1'b0;
		end else if (emit_done) begin
			status               <= done_status_q;
			is_dispatch          <= 1'b0;
			dispatch_handler     <= '0;
			dispatch_context     <= '0;
			dispatch_event       <= '0;
			dispatch_payload     <= '0;
			active_subscriptions <= 5'(32'(active_q));
			last                 <= 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(active_q) == $countones(valid_q))
		else $error("active count out of step with valid bits");

	a_fill_free: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> !valid_q[free_idx_q])
		else $error("subscribe writes an occupied slot");

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done |=> (state_q == S_IDLE) && out_valid_q && last)
		else $error("completion result not issued");
`endif

endmodule

/* sv/event_subscription_dispatcher_top.sv */
// ----------------------------------------------------------------------------
// Event subscription dispatcher
// Publish/subscribe table with a decoupled command queue and table engine.
// ----------------------------------------------------------------------------
// Items enter a two-item queue and are run one at a time by the table engine.
// Clear and null-handler items need no scan. Subscribe, unsubscribe and
// publish scan the used slots one per cycle through the table memory's single
// read port, pausing while a publish dispatch is held up by a stalled output.
// Results leave through an output register, so the queue keeps taking items
// while a result waits.
module event_subscription_dispatcher_top #(
	parameter int TABLE_SLOTS = esd_pkg::TABLE_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_wdata,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   command,
	input  logic [15:0]  event_number,
	input  logic [15:0]  handler_id,
	input  logic [31:0]  context_word,
	input  logic [31:0]  payload_word,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   status,
	output logic         is_dispatch,
	output logic [15:0]  dispatch_handler,
	output logic [31:0]  dispatch_context,
	output logic [15:0]  dispatch_event,
	output logic [31:0]  dispatch_payload,
	output logic [4:0]   active_subscriptions,
	output logic         last
);

	logic [4:0]     slots_in_use_q;
	logic           q_valid;
	logic           q_ready;
	esd_pkg::cmd_t  q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= esd_pkg::SLOTS_RST;
		end else if (cfg_we) begin
			slots_in_use_q <= cfg_wdata;
		end
	end

	esd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.event_number (event_number),
		.handler_id   (handler_id),
		.context_word (context_word),
		.payload_word (payload_word),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_cmd        (q_cmd)
	);

	esd_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.slots_in_use         (slots_in_use_q),
		.q_valid              (q_valid),
		.q_ready              (q_ready),
		.q_cmd                (q_cmd),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.status               (status),
		.is_dispatch          (is_dispatch),
		.dispatch_handler     (dispatch_handler),
		.dispatch_context     (dispatch_context),
		.dispatch_event       (dispatch_event),
		.dispatch_payload     (dispatch_payload),
		.active_subscriptions (active_subscriptions),
		.last                 (last)
	);

endmodule
